FILE: hdl/fdfm_pkg.sv
// Package for the fall detector: constants, state type and controller/datapath command structs.
package fdfm_pkg;

   localparam int FracBits = 8;
   localparam int CoefBits = 16;
   localparam int RegWidth = 16;
   localparam int CsrIndexWidth = 3;
   localparam int LevelWidth = 18;

   localparam logic [CsrIndexWidth-1:0] RegHighThreshold = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegLowThreshold  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegGravityOffset = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegWindowSamples = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegHpGain        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegHpFeedback    = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegLpGain        = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegLpFeedback    = 3'd7;

   // Multiply-accumulate operand selects for the shared multiplier.
   typedef enum logic [1:0] {
      MAC_HP_FB,
      MAC_HP_GAIN,
      MAC_LP_GAIN,
      MAC_LP_FB
   } mac_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT,
      ST_MAC,
      ST_HP_DONE,
      ST_LP_DONE,
      ST_DECIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic        load;
      logic        square;
      logic        sqrt_step;
      logic        mac_clear;
      logic        mac_step;
      mac_sel_type mac_sel;
      logic        hp_finish;
      logic        lp_finish;
      logic        decide;
   } cmd_type;

   typedef struct packed {
      logic square_done;
      logic sqrt_done;
      logic mac_done;
   } status_type;

endpackage

FILE: hdl/fall_detector_filtered_magnitude.sv
// Each sample runs through the states idle, square (the three axes in turn through one squarer),
// square root (a load plus 16 steps), two filter passes of two multiplies and a finish, decide
// and output; a new request is accepted only in the idle state, once the last sample is through.
// A finished response waits in an output register; the next sample stops before its decide
// step until that response has been taken, so a stalled receiver also holds back the datapath.
// Reset is synchronous, active high; it restores register defaults and clears filter state.
module fall_detector_filtered_magnitude #(
   parameter int FRAC_BITS = fdfm_pkg::FracBits,
   parameter int COEF_BITS = fdfm_pkg::CoefBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // accel_x, accel_y, accel_z, cancel_press
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // filtered_level, impact, fall, alert, cancel_flag_out
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   fdfm_pkg::cmd_type cmd;
   fdfm_pkg::status_type status;
   logic [21:0] result;

   fdfm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .cmd(cmd)
   );

   fdfm_datapath #(.FRAC_BITS(FRAC_BITS), .COEF_BITS(COEF_BITS)) u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tdata(req_tdata[48:0]), .cmd(cmd), .status(status), .result(result)
   );

   // Result is held in the datapath register until the next decide, after this transfer.
   assign rsp_tdata = {2'b00, result};

endmodule

FILE: hdl/fdfm_ctrl.sv
// Controller state machine sequencing the datapath and the stream handshake.
module fdfm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  fdfm_pkg::status_type status,
   output fdfm_pkg::cmd_type    cmd
);

   fdfm_pkg::state_type state_ff, state_in;
   logic [1:0] mac_cnt_ff, mac_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == fdfm_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   // The result register may be overwritten once any waiting response leaves.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      mac_cnt_in = mac_cnt_ff;
      unique case (state_ff)
         fdfm_pkg::ST_IDLE: if (accept) state_in = fdfm_pkg::ST_SQUARE;
         fdfm_pkg::ST_SQUARE: if (status.square_done) state_in = fdfm_pkg::ST_SQRT;
         fdfm_pkg::ST_SQRT: if (status.sqrt_done) begin
            state_in = fdfm_pkg::ST_MAC;
            mac_cnt_in = 2'd0;
         end
         fdfm_pkg::ST_MAC: if (status.mac_done) begin
            mac_cnt_in = mac_cnt_ff + 2'd1;
            if (mac_cnt_ff == 2'd1) state_in = fdfm_pkg::ST_HP_DONE;
            else if (mac_cnt_ff == 2'd3) state_in = fdfm_pkg::ST_LP_DONE;
         end
         fdfm_pkg::ST_HP_DONE: state_in = fdfm_pkg::ST_MAC;
         fdfm_pkg::ST_LP_DONE: state_in = fdfm_pkg::ST_DECIDE;
         fdfm_pkg::ST_DECIDE: if (out_free) state_in = fdfm_pkg::ST_OUTPUT;
         fdfm_pkg::ST_OUTPUT: if (out_free) state_in = fdfm_pkg::ST_IDLE;
         default: state_in = fdfm_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      cmd.mac_sel = fdfm_pkg::mac_sel_type'(mac_cnt_ff);
      unique case (state_ff)
         fdfm_pkg::ST_IDLE: cmd.load = accept;
         fdfm_pkg::ST_SQUARE: cmd.square = 1'b1;
         fdfm_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cmd.mac_clear = status.sqrt_done;
         end
         fdfm_pkg::ST_MAC: cmd.mac_step = 1'b1;
         fdfm_pkg::ST_HP_DONE: cmd.hp_finish = 1'b1;
         fdfm_pkg::ST_LP_DONE: cmd.lp_finish = 1'b1;
         fdfm_pkg::ST_DECIDE: cmd.decide = out_free;
         default: ;
      endcase
   end

   // Output register valid: a result waits here while the next sample is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == fdfm_pkg::ST_OUTPUT && out_free)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdfm_pkg::ST_IDLE;
         mac_cnt_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mac_cnt_ff <= mac_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == fdfm_pkg::ST_IDLE) else $error("ready outside idle");
   a_load_goes_square: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == fdfm_pkg::ST_SQUARE) else $error("bad sequence");
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdfm_pkg::ST_OUTPUT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result lost");
`endif

endmodule

FILE: hdl/fdfm_datapath.sv
// Datapath: squares, iterative square root, shared multiplier filters and event logic.
module fdfm_datapath #(
   parameter int FRAC_BITS = fdfm_pkg::FracBits,
   parameter int COEF_BITS = fdfm_pkg::CoefBits
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [fdfm_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [fdfm_pkg::RegWidth-1:0]        csr_wdata,
   input  logic [48:0]                          req_tdata,
   input  fdfm_pkg::cmd_type                    cmd,
   output fdfm_pkg::status_type                 status,
   output logic [fdfm_pkg::LevelWidth+3:0]      result
);

   localparam int AccW = 64;

   // Configuration registers.
   logic signed [15:0] high_thr_ff, low_thr_ff;
   logic [15:0] grav_ff, window_ff, hp_gain_ff, hp_fb_ff, lp_gain_ff, lp_fb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_thr_ff <= 16'sd5120;
         low_thr_ff  <= 16'sd1024;
         grav_ff     <= 16'd2150;
         window_ff   <= 16'd1000;
         hp_gain_ff  <= 16'd65025;
         hp_fb_ff    <= 16'd64515;
         lp_gain_ff  <= 16'd1996;
         lp_fb_ff    <= 16'd61544;
      end else if (csr_we) begin
         unique case (csr_index)
            fdfm_pkg::RegHighThreshold: high_thr_ff <= csr_wdata;
            fdfm_pkg::RegLowThreshold:  low_thr_ff  <= csr_wdata;
            fdfm_pkg::RegGravityOffset: grav_ff     <= csr_wdata;
            fdfm_pkg::RegWindowSamples: window_ff   <= csr_wdata;
            fdfm_pkg::RegHpGain:        hp_gain_ff  <= csr_wdata;
            fdfm_pkg::RegHpFeedback:    hp_fb_ff    <= csr_wdata;
            fdfm_pkg::RegLpGain:        lp_gain_ff  <= csr_wdata;
            fdfm_pkg::RegLpFeedback:    lp_fb_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sample capture and sum of squares, one axis per cycle through one squarer.
   logic signed [15:0] ax_ff [3];
   logic press_ff;
   logic [1:0] sq_cnt_ff;
   logic [31:0] sq_sum_ff;
   logic signed [31:0] sq_term;
   assign sq_term = ax_ff[sq_cnt_ff] * ax_ff[sq_cnt_ff];
   assign status.square_done = cmd.square && (sq_cnt_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff[0] <= req_tdata[15:0];
         ax_ff[1] <= req_tdata[31:16];
         ax_ff[2] <= req_tdata[47:32];
         press_ff <= req_tdata[48];
         sq_cnt_ff <= 2'd0;
         sq_sum_ff <= '0;
      end else if (cmd.square) begin
         sq_sum_ff <= sq_sum_ff + 32'(sq_term);
         sq_cnt_ff <= sq_cnt_ff + 2'd1;
      end
   end

   // Bit-pair square root, one step per cycle over sixteen steps.
   logic [31:0] rem_ff, root_ff, bit_ff;
   logic [31:0] trial;
   logic sq_started_ff;
   assign trial = root_ff + bit_ff;
   assign status.sqrt_done = cmd.sqrt_step && sq_started_ff && (bit_ff[1:0] != 2'd0);

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_started_ff <= 1'b0;
      end else if (cmd.sqrt_step) begin
         if (!sq_started_ff) begin
            rem_ff <= sq_sum_ff;
            root_ff <= '0;
            bit_ff <= 32'h4000_0000;
            sq_started_ff <= 1'b1;
         end else begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
      end
   end

   logic [31:0] root_final;
   assign root_final = (rem_ff >= trial) ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

   // Filter state and shared multiply-accumulate.
   logic signed [31:0] xn_ff, hp_pin_ff, hp_pout_ff, lp_pin_ff, lp_pout_ff, hp_ff, lp_ff;
   logic signed [AccW-1:0] acc_ff;
   logic signed [16:0] coef;
   logic signed [32:0] operand;
   logic signed [49:0] mul_full;
   logic signed [AccW-1:0] product;
   logic signed [AccW-1:0] shifted;
   logic signed [31:0] sat_val;
   logic signed [AccW-1:0] diff;

   assign diff = (AccW'(xn_ff) - AccW'(hp_pin_ff)) <<< FRAC_BITS;
   always_comb begin
      unique case (cmd.mac_sel)
         fdfm_pkg::MAC_HP_FB:   begin coef = {1'b0, hp_fb_ff};   operand = 33'(hp_pout_ff); end
         fdfm_pkg::MAC_HP_GAIN: begin coef = {1'b0, hp_gain_ff}; operand = diff[32:0]; end
         fdfm_pkg::MAC_LP_GAIN: begin
            coef = {1'b0, lp_gain_ff};
            operand = 33'(hp_ff) + 33'(lp_pin_ff);
         end
         default: begin coef = {1'b0, lp_fb_ff}; operand = 33'(lp_pout_ff); end
      endcase
   end
   // A 33 by 17 bit signed product is exact in 50 bits.
   assign mul_full = operand * coef;
   assign product = AccW'(mul_full);
   assign status.mac_done = cmd.mac_step;
   assign shifted = acc_ff >>> COEF_BITS;
   assign sat_val = (shifted > 64'sd2147483647) ? 32'sh7fffffff :
                    (shifted < -64'sd2147483648) ? 32'sh80000000 : shifted[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_pin_ff <= '0; hp_pout_ff <= '0; lp_pin_ff <= '0; lp_pout_ff <= '0;
      end else begin
         if (cmd.mac_clear) begin
            xn_ff <= 32'($signed({1'b0, root_final})) - 32'($signed({1'b0, grav_ff}));
            acc_ff <= '0;
         end
         if (cmd.mac_step) acc_ff <= acc_ff + product;
         if (cmd.hp_finish) begin
            hp_ff <= sat_val;
            acc_ff <= '0;
         end
         if (cmd.lp_finish) begin
            lp_ff <= sat_val;
            hp_pin_ff <= xn_ff;
            hp_pout_ff <= hp_ff;
            lp_pin_ff <= hp_ff;
            lp_pout_ff <= sat_val;
         end
      end
   end

   // Level and event state.
   logic signed [31:0] lvl_full;
   logic signed [17:0] level;
   assign lvl_full = lp_ff >>> FRAC_BITS;
   assign level = (lvl_full > 32'sd131071) ? 18'sd131071 :
                  (lvl_full < -32'sd131072) ? -18'sd131072 : lvl_full[17:0];

   logic armed_ff, cancelled_ff, alert_done_ff;
   logic [15:0] win_ff;
   logic [21:0] result_ff;
   always_ff @(posedge clock) begin
      logic a, c, ad, fi, ff, fa, fc;
      logic [15:0] w;
      if (reset) begin
         armed_ff <= 1'b0; cancelled_ff <= 1'b0; alert_done_ff <= 1'b0; win_ff <= '0;
      end else if (cmd.decide) begin
         a = armed_ff; c = cancelled_ff; ad = alert_done_ff; w = win_ff;
         fi = 1'b0; ff = 1'b0; fa = 1'b0; fc = 1'b0;
         if (press_ff && a) begin c = 1'b1; a = 1'b0; fc = 1'b1; end
         if (w != 16'd0) begin
            w = w - 16'd1;
            if (w == 16'd0 && !c) begin ad = 1'b1; a = 1'b0; fa = 1'b1; end
         end
         if (!a && level > 18'(high_thr_ff)) begin
            a = 1'b1; c = 1'b0; ad = 1'b0; fi = 1'b1;
            w = (window_ff != 16'd0) ? window_ff : 16'd1;
         end else if (a && level < 18'(low_thr_ff)) begin
            ff = !c && !ad; a = 1'b0;
         end
         armed_ff <= a; cancelled_ff <= c; alert_done_ff <= ad; win_ff <= w;
         result_ff <= {fc, fa, ff, fi, level};
      end
   end
   assign result = result_ff;

`ifndef SYNTH
   a_sqrt_after_square: assert property (@(posedge clock) disable iff (reset)
      status.square_done |=> !sq_started_ff) else $error("sqrt started early");
   a_cancel_clears_arm: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && press_ff && armed_ff && !(level > 18'(high_thr_ff)))
      |=> !armed_ff) else $error("cancel kept armed");
   a_impact_loads_window: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && !armed_ff && !(press_ff && armed_ff) && level > 18'(high_thr_ff))
      |=> win_ff != 16'd0) else $error("window not started");
`endif

endmodule
